// File: src/first_fit_heap_allocator_defines.svh
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_defines
// Assertion macros used by the allocator module.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, codes and field layout of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int FREE_SLOTS_DEF = 64;
  localparam int USED_SLOTS_DEF = 64;

  localparam int ADDR_W = 32;
  localparam int OFF_W  = 16;
  localparam int LEN_W  = 17;
  localparam int ENT_W  = OFF_W + LEN_W;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 3;

  // input tdata layout
  localparam int IN_CMD_LSB  = 0;
  localparam int IN_ADDR_LSB = IN_CMD_LSB + CMD_W;
  localparam int IN_SIZE_LSB = IN_ADDR_LSB + ADDR_W;
  localparam int IN_BITS     = IN_SIZE_LSB + LEN_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_STAT_LSB = ADDR_W;
  localparam int OUT_MOV_LSB  = OUT_STAT_LSB + STAT_W;
  localparam int OUT_BITS     = OUT_MOV_LSB + 1;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_RESIZE = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

// File: src/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with coalescing over two address-sorted tables.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | command, block_address, request_size
// out     | out | out_tvalid / out_tready| result_address, status, moved
// cfg     | in  | cfg_valid / cfg_ready  | base_address
//
// Every table access is a RAM read state followed by an evaluate or write
// state, so an item's run time grows with the entries its scans and shifts
// visit, and a relocating resize runs the most scans and shifts.
// After reset the S_INIT state seeds free entry 0 before the first transfer is taken.
// A finished result waits in the output register; the next item is taken and
// worked on meanwhile, and only its own completion waits for out_tready.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
  parameter int FREE_SLOTS = ffha_pkg::FREE_SLOTS_DEF,
  parameter int USED_SLOTS = ffha_pkg::USED_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // command, block_address, request_size
  input  logic [ffha_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_address, status, moved
  output logic [ffha_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ffha_pkg::ADDR_W-1:0]      cfg_data
);

  import ffha_pkg::*;

  localparam int MAX_SLOTS = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int FAW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int UAW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
  localparam logic T_FREE = 1'b0;
  localparam logic T_USED = 1'b1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_EV, S_REM_RD, S_REM_WR,
    S_INS_RD, S_INS_WR, S_READ, S_READ_EV, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    PH_FIT, PH_UINS, PH_UPUT, PH_END, PH_F_FOUND, PH_R_FOUND, PH_R_RIGHT,
    PH_R_GROWN, PH_R_OLD, PH_R_OREM, PH_P_POS, PH_P_INS, PH_P_RNB, PH_P_RM,
    PH_P_LNB, PH_P_LM
  } phase_t;

  typedef enum logic [1:0] {SM_FIT, SM_POS, SM_EQ} smode_t;

  state_t  state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  smode_t  smode_r, smode_nxt;
  logic    tsel_r, tsel_nxt;
  logic [CW-1:0] idx_r, idx_nxt, j_r, j_nxt, k_r, k_nxt, u_r, u_nxt;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt, used_cnt_r, used_cnt_nxt;
  logic    found_r, found_nxt;
  logic [ENT_W-1:0] ent_r, ent_nxt, new_r, new_nxt;
  logic [LEN_W-1:0] key_r, key_nxt;
  logic    key_ok_r, key_ok_nxt;
  cmd_t    cmd_r, cmd_nxt;
  logic [LEN_W-1:0] size_r, size_nxt, l_r, l_nxt, pl_r, pl_nxt;
  logic [OFF_W-1:0] s_r, s_nxt, ns_r, ns_nxt, ps_r, ps_nxt, res_off_r, res_off_nxt;
  status_t st_r, st_nxt;
  logic    mv_r, mv_nxt, has_r, has_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  status_t out_stat_r, out_stat_nxt;
  logic    out_mov_r, out_mov_nxt;
  logic [ADDR_W-1:0] base_r;

  // memory port controls
  logic             mem_we, mem_wsel, mem_re, mem_rsel;
  logic [CW-1:0]    mem_wa, mem_ra;
  logic [ENT_W-1:0] mem_wd;
  logic [ENT_W-1:0] f_rdata, u_rdata, rdata;

  logic [CW-1:0]    cnt_sel;
  logic [OFF_W-1:0] ent_start;
  logic [LEN_W-1:0] ent_len, ent_start17, rd_start17, rd_len, grow;
  logic [ADDR_W-1:0] in_addr, in_off;
  logic [LEN_W-1:0] in_size;
  logic             hit;

  assign rdata       = (tsel_r == T_USED) ? u_rdata : f_rdata;
  assign cnt_sel     = (tsel_r == T_USED) ? used_cnt_r : free_cnt_r;
  assign ent_start   = ent_r[OFF_W-1:0];
  assign ent_len     = ent_r[ENT_W-1:OFF_W];
  assign ent_start17 = {1'b0, ent_start};
  assign rd_start17  = {1'b0, rdata[OFF_W-1:0]};
  assign rd_len      = rdata[ENT_W-1:OFF_W];
  assign grow        = size_r - l_r;
  assign in_addr     = in_tdata[IN_ADDR_LSB +: ADDR_W];
  assign in_size     = in_tdata[IN_SIZE_LSB +: LEN_W];
  assign in_off      = in_addr - base_r;

  always_comb begin
    unique case (smode_r)
      SM_FIT: hit = (key_r <= rd_len);
      SM_POS: hit = (rd_start17 >= key_r);
      SM_EQ:  hit = key_ok_r && (rd_start17 == key_r);
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;  smode_nxt = smode_r;
    tsel_nxt = tsel_r;    idx_nxt = idx_r;      j_nxt = j_r;
    k_nxt = k_r;          u_nxt = u_r;          found_nxt = found_r;
    free_cnt_nxt = free_cnt_r;  used_cnt_nxt = used_cnt_r;
    ent_nxt = ent_r;      new_nxt = new_r;      key_nxt = key_r;
    key_ok_nxt = key_ok_r; cmd_nxt = cmd_r;     size_nxt = size_r;
    l_nxt = l_r;          pl_nxt = pl_r;        s_nxt = s_r;
    ns_nxt = ns_r;        ps_nxt = ps_r;        res_off_nxt = res_off_r;
    st_nxt = st_r;        mv_nxt = mv_r;        has_nxt = has_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt = out_addr_r;  out_stat_nxt = out_stat_r;  out_mov_nxt = out_mov_r;
    mem_we = 1'b0;  mem_wsel = T_FREE;  mem_wa = '0;  mem_wd = '0;
    mem_re = 1'b0;  mem_rsel = T_FREE;  mem_ra = '0;

    unique case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wsel = T_FREE;
        mem_wd = {LEN_W'(HEAP_BYTES), {OFF_W{1'b0}}};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = cmd_t'(in_tdata[IN_CMD_LSB +: CMD_W]);
          size_nxt = in_size;
          st_nxt = ST_OK;
          mv_nxt = 1'b0;
          has_nxt = 1'b0;
          idx_nxt = '0;
          state_nxt = S_DONE;
          unique case (in_tdata[IN_CMD_LSB +: CMD_W])
            CMD_ALLOC: begin
              if (in_size == '0) begin
                st_nxt = ST_ZERO;
              end else if (used_cnt_r >= CW'(USED_SLOTS)) begin
                st_nxt = ST_FULL;
              end else begin
                tsel_nxt = T_FREE;  smode_nxt = SM_FIT;
                key_nxt = in_size;  key_ok_nxt = 1'b1;
                phase_nxt = PH_FIT; state_nxt = S_SCAN_RD;
              end
            end
            CMD_FREE: begin
              if (free_cnt_r >= CW'(FREE_SLOTS)) begin
                st_nxt = ST_FULL;
              end else begin
                tsel_nxt = T_USED;  smode_nxt = SM_EQ;
                key_nxt = {1'b0, in_off[OFF_W-1:0]};
                key_ok_nxt = (in_off[ADDR_W-1:OFF_W] == '0);
                phase_nxt = PH_F_FOUND; state_nxt = S_SCAN_RD;
              end
            end
            CMD_RESIZE: begin
              if (in_size == '0) begin
                st_nxt = ST_ZERO;
              end else begin
                tsel_nxt = T_USED;  smode_nxt = SM_EQ;
                key_nxt = {1'b0, in_off[OFF_W-1:0]};
                key_ok_nxt = (in_off[ADDR_W-1:OFF_W] == '0);
                phase_nxt = PH_R_FOUND; state_nxt = S_SCAN_RD;
              end
            end
            default: st_nxt = ST_NOTFOUND;
          endcase
        end
      end

      S_SCAN_RD: begin
        if (idx_r == cnt_sel) begin
          found_nxt = 1'b0;
          state_nxt = S_DISP;
        end else begin
          mem_re = 1'b1;  mem_rsel = tsel_r;  mem_ra = idx_r;
          state_nxt = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        if (hit) begin
          found_nxt = 1'b1;
          ent_nxt = rdata;
          state_nxt = S_DISP;
        end else begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      // shift entries above idx down by one
      S_REM_RD: begin
        if (idx_r + CW'(1) >= cnt_sel) begin
          if (tsel_r == T_USED) begin
            used_cnt_nxt = used_cnt_r - CW'(1);
          end else begin
            free_cnt_nxt = free_cnt_r - CW'(1);
          end
          state_nxt = S_DISP;
        end else begin
          mem_re = 1'b1;  mem_rsel = tsel_r;  mem_ra = idx_r + CW'(1);
          state_nxt = S_REM_WR;
        end
      end

      S_REM_WR: begin
        mem_we = 1'b1;  mem_wsel = tsel_r;  mem_wa = idx_r;  mem_wd = rdata;
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_REM_RD;
      end

      // open a hole at idx by shifting from the top, then drop new_r in
      S_INS_RD: begin
        if (j_r == idx_r) begin
          mem_we = 1'b1;  mem_wsel = tsel_r;  mem_wa = idx_r;  mem_wd = new_r;
          if (tsel_r == T_USED) begin
            used_cnt_nxt = used_cnt_r + CW'(1);
          end else begin
            free_cnt_nxt = free_cnt_r + CW'(1);
          end
          state_nxt = S_DISP;
        end else begin
          mem_re = 1'b1;  mem_rsel = tsel_r;  mem_ra = j_r - CW'(1);
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we = 1'b1;  mem_wsel = tsel_r;  mem_wa = j_r;  mem_wd = rdata;
        j_nxt = j_r - CW'(1);
        state_nxt = S_INS_RD;
      end

      S_READ: begin
        mem_re = 1'b1;  mem_rsel = tsel_r;  mem_ra = idx_r;
        state_nxt = S_READ_EV;
      end

      S_READ_EV: begin
        ent_nxt = rdata;
        state_nxt = S_DISP;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt = has_r ? (base_r + {{(ADDR_W-OFF_W){1'b0}}, res_off_r}) : '0;
          out_stat_nxt = st_r;
          out_mov_nxt = mv_r;
          state_nxt = S_IDLE;
        end
      end

      S_DISP: begin
        unique case (phase_r)
          // carve from the start of the first fitting chunk
          PH_FIT: begin
            if (!found_r) begin
              st_nxt = ST_NOSPACE;
              state_nxt = S_DONE;
            end else begin
              ns_nxt = ent_start;
              tsel_nxt = T_FREE;
              phase_nxt = PH_UINS;
              if (ent_len == size_r) begin
                state_nxt = S_REM_RD;
              end else begin
                mem_we = 1'b1;  mem_wsel = T_FREE;  mem_wa = idx_r;
                mem_wd = {ent_len - size_r, ent_start + size_r[OFF_W-1:0]};
              end
            end
          end

          PH_UINS: begin
            tsel_nxt = T_USED;  smode_nxt = SM_POS;
            key_nxt = {1'b0, ns_r};  key_ok_nxt = 1'b1;  idx_nxt = '0;
            phase_nxt = PH_UPUT;  state_nxt = S_SCAN_RD;
          end

          PH_UPUT: begin
            new_nxt = {size_r, ns_r};
            j_nxt = used_cnt_r;
            tsel_nxt = T_USED;
            state_nxt = S_INS_RD;
            if (cmd_r == CMD_ALLOC) begin
              has_nxt = 1'b1;
              res_off_nxt = ns_r;
              phase_nxt = PH_END;
            end else begin
              phase_nxt = PH_R_OLD;
            end
          end

          PH_END: state_nxt = S_DONE;

          PH_F_FOUND: begin
            if (!found_r) begin
              st_nxt = ST_NOTFOUND;
              state_nxt = S_DONE;
            end else begin
              ps_nxt = ent_start;  pl_nxt = ent_len;
              tsel_nxt = T_USED;
              phase_nxt = PH_P_POS;  state_nxt = S_REM_RD;
            end
          end

          PH_R_FOUND: begin
            if (!found_r) begin
              st_nxt = ST_NOTFOUND;
              state_nxt = S_DONE;
            end else begin
              s_nxt = ent_start;  l_nxt = ent_len;  u_nxt = idx_r;
              if (size_r == ent_len) begin
                has_nxt = 1'b1;  res_off_nxt = ent_start;
                state_nxt = S_DONE;
              end else if (size_r < ent_len) begin
                if (free_cnt_r >= CW'(FREE_SLOTS)) begin
                  st_nxt = ST_FULL;
                  state_nxt = S_DONE;
                end else begin
                  mem_we = 1'b1;  mem_wsel = T_USED;  mem_wa = idx_r;
                  mem_wd = {size_r, ent_start};
                  has_nxt = 1'b1;  res_off_nxt = ent_start;
                  ps_nxt = ent_start + size_r[OFF_W-1:0];
                  pl_nxt = ent_len - size_r;
                  phase_nxt = PH_P_POS;
                end
              end else begin
                // look for a free chunk right behind the block
                tsel_nxt = T_FREE;  smode_nxt = SM_EQ;
                key_nxt = ent_start17 + ent_len;  key_ok_nxt = 1'b1;
                idx_nxt = '0;
                phase_nxt = PH_R_RIGHT;  state_nxt = S_SCAN_RD;
              end
            end
          end

          PH_R_RIGHT: begin
            if (found_r && ent_len >= grow) begin
              tsel_nxt = T_FREE;
              phase_nxt = PH_R_GROWN;
              if (ent_len == grow) begin
                state_nxt = S_REM_RD;
              end else begin
                mem_we = 1'b1;  mem_wsel = T_FREE;  mem_wa = idx_r;
                mem_wd = {ent_len - grow, ent_start + grow[OFF_W-1:0]};
              end
            end else if (free_cnt_r >= CW'(FREE_SLOTS) || used_cnt_r >= CW'(USED_SLOTS)) begin
              st_nxt = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              tsel_nxt = T_FREE;  smode_nxt = SM_FIT;
              key_nxt = size_r;  key_ok_nxt = 1'b1;  idx_nxt = '0;
              phase_nxt = PH_FIT;  state_nxt = S_SCAN_RD;
            end
          end

          PH_R_GROWN: begin
            mem_we = 1'b1;  mem_wsel = T_USED;  mem_wa = u_r;
            mem_wd = {size_r, s_r};
            has_nxt = 1'b1;  res_off_nxt = s_r;
            state_nxt = S_DONE;
          end

          PH_R_OLD: begin
            tsel_nxt = T_USED;  smode_nxt = SM_EQ;
            key_nxt = {1'b0, s_r};  key_ok_nxt = 1'b1;  idx_nxt = '0;
            phase_nxt = PH_R_OREM;  state_nxt = S_SCAN_RD;
          end

          PH_R_OREM: begin
            has_nxt = 1'b1;  res_off_nxt = ns_r;  mv_nxt = 1'b1;
            if (found_r) begin
              ps_nxt = s_r;  pl_nxt = l_r;
              tsel_nxt = T_USED;
              phase_nxt = PH_P_POS;  state_nxt = S_REM_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end

          // return ps/pl to the free table and merge with neighbors
          PH_P_POS: begin
            tsel_nxt = T_FREE;  smode_nxt = SM_POS;
            key_nxt = {1'b0, ps_r};  key_ok_nxt = 1'b1;  idx_nxt = '0;
            phase_nxt = PH_P_INS;  state_nxt = S_SCAN_RD;
          end

          PH_P_INS: begin
            k_nxt = idx_r;
            new_nxt = {pl_r, ps_r};
            j_nxt = free_cnt_r;
            tsel_nxt = T_FREE;
            phase_nxt = PH_P_RNB;  state_nxt = S_INS_RD;
          end

          PH_P_RNB: begin
            phase_nxt = PH_P_LNB;
            if (k_r + CW'(1) < free_cnt_r) begin
              idx_nxt = k_r + CW'(1);
              tsel_nxt = T_FREE;
              phase_nxt = PH_P_RM;  state_nxt = S_READ;
            end
          end

          PH_P_RM: begin
            phase_nxt = PH_P_LNB;
            if ({1'b0, ps_r} + pl_r == ent_start17) begin
              pl_nxt = pl_r + ent_len;
              mem_we = 1'b1;  mem_wsel = T_FREE;  mem_wa = k_r;
              mem_wd = {pl_r + ent_len, ps_r};
              idx_nxt = k_r + CW'(1);
              state_nxt = S_REM_RD;
            end
          end

          PH_P_LNB: begin
            if (k_r != '0) begin
              idx_nxt = k_r - CW'(1);
              tsel_nxt = T_FREE;
              phase_nxt = PH_P_LM;  state_nxt = S_READ;
            end else begin
              state_nxt = S_DONE;
            end
          end

          PH_P_LM: begin
            if (ent_start17 + ent_len == {1'b0, ps_r}) begin
              mem_we = 1'b1;  mem_wsel = T_FREE;  mem_wa = k_r - CW'(1);
              mem_wd = {ent_len + pl_r, ent_start};
              idx_nxt = k_r;
              phase_nxt = PH_END;  state_nxt = S_REM_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end

          default: state_nxt = S_DONE;
        endcase
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      phase_r <= PH_END;
      free_cnt_r <= CW'(1);
      used_cnt_r <= '0;
      out_valid_r <= 1'b0;
      base_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      free_cnt_r <= free_cnt_nxt;
      used_cnt_r <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        base_r <= cfg_data;
      end
    end
    smode_r <= smode_nxt;   tsel_r <= tsel_nxt;   idx_r <= idx_nxt;
    j_r <= j_nxt;           k_r <= k_nxt;         u_r <= u_nxt;
    found_r <= found_nxt;   ent_r <= ent_nxt;     new_r <= new_nxt;
    key_r <= key_nxt;       key_ok_r <= key_ok_nxt; cmd_r <= cmd_nxt;
    size_r <= size_nxt;     l_r <= l_nxt;         pl_r <= pl_nxt;
    s_r <= s_nxt;           ns_r <= ns_nxt;       ps_r <= ps_nxt;
    res_off_r <= res_off_nxt; st_r <= st_nxt;     mv_r <= mv_nxt;
    has_r <= has_nxt;       out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt; out_mov_r <= out_mov_nxt;
  end

  ffha_ram #(.WIDTH(ENT_W), .DEPTH(FREE_SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (mem_we && mem_wsel == T_FREE),
    .waddr (mem_wa[FAW-1:0]),
    .wdata (mem_wd),
    .re    (mem_re && mem_rsel == T_FREE),
    .raddr (mem_ra[FAW-1:0]),
    .rdata (f_rdata)
  );

  ffha_ram #(.WIDTH(ENT_W), .DEPTH(USED_SLOTS)) u_used_ram (
    .clk   (clk),
    .we    (mem_we && mem_wsel == T_USED),
    .waddr (mem_wa[UAW-1:0]),
    .wdata (mem_wd),
    .re    (mem_re && mem_rsel == T_USED),
    .raddr (mem_ra[UAW-1:0]),
    .rdata (u_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_mov_r, out_stat_r, out_addr_r};

  `FFHA_ASSERT_SAME(a_cnt_bound, 1'b1, (free_cnt_r <= CW'(FREE_SLOTS)) && (used_cnt_r <= CW'(USED_SLOTS)), "table count beyond capacity")
  `FFHA_ASSERT_SAME(a_ins_room, state_r == S_INS_RD, (tsel_r == T_USED) ? (used_cnt_r < CW'(USED_SLOTS)) : (free_cnt_r < CW'(FREE_SLOTS)), "insert into full table")
  `FFHA_ASSERT_SAME(a_fail_zero, out_valid_r && out_stat_r != ST_OK, out_addr_r == '0 && !out_mov_r, "failed result carries address or move flag")
  `FFHA_ASSERT_NEXT(a_done_load, state_r == S_DONE && (!out_valid_r || out_tready), out_valid_r && state_r == S_IDLE, "result not loaded on completion")

endmodule

// File: src/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
